### sv/spq_pkg.sv
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // fixed field widths of one request and one result
  localparam int unsigned CMD_BITS     = 2;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned PRIO_BITS    = 4;
  localparam int unsigned OCC_BITS     = 5;

  // operation codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NOP    = 2'd3
  } spq_cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } spq_status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT
  } spq_state_e;

  // one request
  typedef struct packed {
    spq_cmd_e                cmd;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [PRIO_BITS-1:0]    priority_req;
  } spq_req_t;

  // one result
  typedef struct packed {
    spq_status_e             status;
    logic [PAYLOAD_BITS-1:0] entry_payload;
    logic [PRIO_BITS-1:0]    entry_priority;
    logic [OCC_BITS-1:0]     occupancy;
    logic                    last;
  } spq_res_t;

  // one stored queue entry
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [PRIO_BITS-1:0]    prio;
  } spq_entry_t;

endpackage

`default_nettype wire

### sv/spq_mem.sv
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module spq_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire spq_pkg::spq_entry_t        wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output spq_pkg::spq_entry_t             rdata_o
);

  spq_pkg::spq_entry_t mem_q [DEPTH];
  spq_pkg::spq_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, output registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/spq_ctrl.sv
// sequencer: scans the entry store and shifts entries for push and delete
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire spq_pkg::spq_req_t         req_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output spq_pkg::spq_res_t              res_o,
  output logic                           mem_we_o,
  output logic [$clog2(DEPTH)-1:0]       mem_waddr_o,
  output spq_pkg::spq_entry_t            mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(DEPTH)-1:0]       mem_raddr_o,
  input  wire spq_pkg::spq_entry_t       mem_rdata_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned OccW = spq_pkg::OCC_BITS;

  spq_pkg::spq_state_e state_q, state_d;
  spq_pkg::spq_req_t   op_q, op_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       left_q, left_d;
  logic [AW-1:0]       raddr_q, raddr_d;
  logic [AW-1:0]       didx_q, didx_d;
  logic                dv_q, dv_d;
  logic                found_q, found_d;
  logic                strobe_q, strobe_d;
  spq_pkg::spq_res_t   res_q, res_d;

  spq_pkg::spq_entry_t new_entry;
  logic                last_idx;
  logic                match;

  function automatic spq_pkg::spq_res_t mk_res(spq_pkg::spq_status_e st,
                                               spq_pkg::spq_entry_t e,
                                               logic [CW-1:0] occ,
                                               logic fin);
    spq_pkg::spq_res_t r;
    r.status         = st;
    r.entry_payload  = e.payload;
    r.entry_priority = e.prio;
    r.occupancy      = OccW'(occ);
    r.last           = fin;
    return r;
  endfunction

  assign new_entry = '{payload: op_q.payload, prio: op_q.priority_req};
  assign last_idx  = (didx_q == AW'(cnt_q - 1'b1));
  assign match     = (mem_rdata_i.payload == op_q.payload);

  // next state, memory accesses and results
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    raddr_d     = raddr_q;
    didx_d      = didx_q;
    dv_d        = 1'b0;
    found_d     = found_q;
    strobe_d    = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = raddr_q;

    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (start_i) begin
          op_d    = req_i;
          found_d = 1'b0;
          unique case (req_i.cmd)
            spq_pkg::CMD_PUSH: begin
              if (cnt_q == CW'(DEPTH)) begin
                strobe_d = 1'b1;
                res_d    = mk_res(spq_pkg::ST_FULL, '0, cnt_q, 1'b1);
              end else if (cnt_q == '0) begin
                state_d = spq_pkg::S_INSERT;
              end else begin
                // walk from the tail toward the head
                raddr_d = AW'(cnt_q - 1'b1);
                left_d  = cnt_q;
                state_d = spq_pkg::S_SCAN;
              end
            end
            spq_pkg::CMD_DELETE, spq_pkg::CMD_DUMP: begin
              if (cnt_q == '0) begin
                strobe_d = 1'b1;
                res_d    = mk_res(spq_pkg::ST_EMPTY, '0, cnt_q, 1'b1);
              end else begin
                raddr_d = '0;
                left_d  = cnt_q;
                state_d = spq_pkg::S_SCAN;
              end
            end
            default: begin
              strobe_d = 1'b1;
              res_d    = mk_res(spq_pkg::ST_OK, '0, cnt_q, 1'b1);
            end
          endcase
        end
      end

      spq_pkg::S_SCAN: begin
        // issue one read per cycle
        if (left_q != '0) begin
          mem_re_o = 1'b1;
          dv_d     = 1'b1;
          didx_d   = raddr_q;
          left_d   = left_q - 1'b1;
          raddr_d  = (op_q.cmd == spq_pkg::CMD_PUSH) ? raddr_q - 1'b1 : raddr_q + 1'b1;
        end
        // handle the entry read in the previous cycle
        if (dv_q) begin
          unique case (op_q.cmd)
            spq_pkg::CMD_PUSH: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = didx_q + 1'b1;
              if (mem_rdata_i.prio < op_q.priority_req) begin
                // lower priority entry moves one slot back
                mem_wdata_o = mem_rdata_i;
                if (didx_q == '0) begin
                  state_d = spq_pkg::S_INSERT;
                end
              end else begin
                mem_wdata_o = new_entry;
                cnt_d       = cnt_q + 1'b1;
                strobe_d    = 1'b1;
                res_d       = mk_res(spq_pkg::ST_OK, '0, cnt_q + 1'b1, 1'b1);
                state_d     = spq_pkg::S_IDLE;
              end
            end
            spq_pkg::CMD_DELETE: begin
              if (found_q) begin
                // entries after the match move one slot forward
                mem_we_o    = 1'b1;
                mem_waddr_o = didx_q - 1'b1;
                mem_wdata_o = mem_rdata_i;
              end else if (match) begin
                found_d = 1'b1;
              end
              if (last_idx) begin
                strobe_d = 1'b1;
                state_d  = spq_pkg::S_IDLE;
                if (found_q || match) begin
                  cnt_d = cnt_q - 1'b1;
                  res_d = mk_res(spq_pkg::ST_OK, '0, cnt_q - 1'b1, 1'b1);
                end else begin
                  res_d = mk_res(spq_pkg::ST_NOTFOUND, '0, cnt_q, 1'b1);
                end
              end
            end
            default: begin
              // dump: one result per entry
              strobe_d = 1'b1;
              res_d    = mk_res(spq_pkg::ST_OK, mem_rdata_i, cnt_q, last_idx);
              if (last_idx) begin
                state_d = spq_pkg::S_IDLE;
              end
            end
          endcase
        end
      end

      spq_pkg::S_INSERT: begin
        // new entry goes to the head slot
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = new_entry;
        cnt_d       = cnt_q + 1'b1;
        strobe_d    = 1'b1;
        res_d       = mk_res(spq_pkg::ST_OK, '0, cnt_q + 1'b1, 1'b1);
        state_d     = spq_pkg::S_IDLE;
      end

      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spq_pkg::S_IDLE;
      cnt_q    <= '0;
      left_q   <= '0;
      dv_q     <= 1'b0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      dv_q     <= dv_d;
      found_q  <= found_d;
      strobe_q <= strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    raddr_q <= raddr_d;
    didx_q  <= didx_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != spq_pkg::S_IDLE);
  assign res_valid_o = strobe_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### sv/sorted_priority_queue.sv
// top level of the sorted priority queue
//
// Holds up to DEPTH entries (payload tag plus priority), highest priority
// first, arrival order among equal priorities.
// Request channel: req_i is taken at a clock edge with start high and busy
// low. Commands: push, delete first matching payload, dump all entries.
// Result channel: each result sits on res_o for one cycle with res_valid_o
// high; the receiver cannot hold it off. res_o.last marks the final result
// of a request.
// Sequence, with n entries held: a dump walks the store from the head and
// then gives one result per cycle. A push scans up to n entries from the
// tail, a delete all n from the head; full, empty and unused-command cases
// answer in the next cycle. The pace is one entry per cycle, set by the
// single read port of the entry store, which is scanned and rewritten in
// place. A new request can be taken in the cycle the last result shows.
// Reset clears the entry count and the sequencer; the store itself is not
// cleared, as only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire spq_pkg::spq_req_t  req_i,
  output logic                    busy,
  output logic                    res_valid_o,
  output spq_pkg::spq_res_t       res_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  spq_pkg::spq_entry_t mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  spq_pkg::spq_entry_t mem_rdata;

  // sequencer
  spq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry store
  spq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

### sv/spq_checker.sv
// port-level checks of the sorted priority queue and their bind
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               res_valid_o,
  input wire spq_pkg::spq_res_t  res_o
);

  // an accepted request keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o)
    else $error("accepted request neither busy nor answered");

  // results before the final one come while the request is still in work
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result while idle");

  // the final result frees the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("busy after final result");

  // error results end the request and carry no entry
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != spq_pkg::ST_OK)
      |-> res_o.last && (res_o.entry_payload == '0) && (res_o.entry_priority == '0))
    else $error("malformed error result");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire

### bench/sorted_priority_queue_checker.sv
// checker that predicts and scores every result of the sorted priority queue
`timescale 1ns / 1ps

module sorted_priority_queue_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  spq_pkg::spq_req_t req_i,
  input  logic              res_valid_i,
  input  spq_pkg::spq_res_t res_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import spq_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // shadow copy of the queue contents, head at index 0
  spq_entry_t          held [DEPTH];
  logic [OCC_BITS-1:0] held_count;

  // results still owed by the block, oldest first
  spq_res_t expected_results [$];

  // apply one accepted request to the shadow queue and queue up its results
  task automatic queue_apply(input spq_req_t r);
    spq_res_t res;
    int       i;
    int       pos;
    res = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    case (r.cmd)
      CMD_PUSH: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes ahead of the first strictly lower priority
          pos = held_count;
          for (i = 0; i < held_count; i++) begin
            if (pos == held_count && held[i].prio < r.priority_req) pos = i;
          end
          for (i = held_count; i > pos; i--) held[i] = held[i-1];
          held[pos] = '{payload: r.payload, prio: r.priority_req};
          held_count++;
        end
      end
      CMD_DELETE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // first match in queue order
          pos = held_count;
          for (i = 0; i < held_count; i++) begin
            if (pos == held_count && held[i].payload == r.payload) pos = i;
          end
          if (pos == held_count) begin
            res.status = ST_NOTFOUND;
          end else begin
            for (i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end
        end
      end
      CMD_DUMP: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // one result per held entry, last flag on the tail
          for (i = 0; i < held_count; i++) begin
            res.entry_payload  = held[i].payload;
            res.entry_priority = held[i].prio;
            res.occupancy      = held_count;
            res.last           = (i == held_count - 1);
            expected_results.push_back(res);
          end
          return;
        end
      end
      default: begin
        // unused command answers ok with the current occupancy
      end
    endcase
    res.occupancy = held_count;
    expected_results.push_back(res);
  endtask

  // compare one result against the oldest expectation
  task automatic score_result(input spq_res_t got);
    spq_res_t want;
    if (expected_results.size() == 0) begin
      if (fail_count_o < REPORT_LIMIT)
        $display("%t unexpected result: status %0d payload %h prio %0d occ %0d last %0d",
                 $realtime, got.status, got.entry_payload, got.entry_priority,
                 got.occupancy, got.last);
      fail_count_o++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.entry_payload !== want.entry_payload ||
        got.entry_priority !== want.entry_priority ||
        got.occupancy !== want.occupancy || got.last !== want.last) begin
      if (fail_count_o < REPORT_LIMIT) begin
        $display("%t result mismatch", $realtime);
        $display("  expected: status %0d payload %h prio %0d occ %0d last %0d",
                 want.status, want.entry_payload, want.entry_priority,
                 want.occupancy, want.last);
        $display("  actual:   status %0d payload %h prio %0d occ %0d last %0d",
                 got.status, got.entry_payload, got.entry_priority,
                 got.occupancy, got.last);
      end
      fail_count_o++;
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = '0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i) score_result(res_i);
      if (start_i && !busy_i) queue_apply(req_i);
      pending_o <= expected_results.size();
    end
  end

endmodule

### bench/sorted_priority_queue_tb.sv
// stimulus and verdict for the sorted priority queue
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MODE_SPAN     = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  spq_req_t    req_i;
  logic        busy;
  logic        res_valid_o;
  spq_res_t    res_o;
  int unsigned fail_count;
  int unsigned pending_results;

  sorted_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  sorted_priority_queue_checker #(
    .DEPTH(QUEUE_DEPTH)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hold a request until it is taken, after a random number of idle cycles
  task automatic send_request(input spq_req_t r, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // stop sending until every owed result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // random request, biased toward growing or shrinking the queue
  function automatic spq_req_t random_request(input bit filling);
    spq_req_t    r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) r.cmd = CMD_NOP;
    else if (roll < 20) r.cmd = CMD_DUMP;
    else if (roll < (filling ? 35 : 75)) r.cmd = CMD_DELETE;
    else r.cmd = CMD_PUSH;
    // small tag pool so deletes find matches and duplicates occur
    case ($urandom_range(7))
      0: r.payload = 32'h0000_0000;
      1: r.payload = 32'hFFFF_FFFF;
      2: r.payload = 32'hA5A5_5A5A;
      3: r.payload = 32'h0000_0001;
      4: r.payload = 32'h8000_0000;
      5: r.payload = 32'h1234_5678;
      default: r.payload = $urandom;
    endcase
    // cluster priorities to exercise arrival order among equals
    if ($urandom_range(1)) r.priority_req = 4'($urandom_range(15));
    else r.priority_req = 4'd6 + 4'($urandom_range(1));
    return r;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    int unsigned k;
    for (k = 0; k < count; k++)
      send_request(random_request(((k / MODE_SPAN) % 2) == 0), idle_pct);
  endtask

  // edge cases: empty queue, extremes, equal priorities, full queue
  task automatic run_directed();
    int unsigned k;
    send_request('{CMD_DUMP, 32'h0000_0000, 4'd0}, 0);
    send_request('{CMD_DELETE, 32'h0000_0000, 4'd0}, 0);
    send_request('{CMD_NOP, 32'hFFFF_FFFF, 4'd15}, 0);
    send_request('{CMD_PUSH, 32'h0000_0000, 4'd0}, 0);
    send_request('{CMD_PUSH, 32'hFFFF_FFFF, 4'd15}, 0);
    send_request('{CMD_PUSH, 32'h5A5A_5A5A, 4'd15}, 0);
    send_request('{CMD_PUSH, 32'h0000_0001, 4'd7}, 0);
    send_request('{CMD_DELETE, 32'hDEAD_BEEF, 4'd0}, 0);
    send_request('{CMD_DELETE, 32'h0000_0001, 4'd0}, 0);
    send_request('{CMD_DUMP, 32'h0000_0000, 4'd0}, 0);
    for (k = 0; k < 13; k++)
      send_request('{CMD_PUSH, 32'h1000_0000 + k, 4'(k)}, 0);
    send_request('{CMD_PUSH, 32'hCAFE_F00D, 4'd15}, 0);
    send_request('{CMD_DUMP, 32'h0000_0000, 4'd0}, 0);
  endtask

  // watchdog on cycles with no request and no result
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || res_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // reset, directed part, then three random phases
  initial begin : stimulus
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    wait_for_results();
    run_random(115, 26);
    wait_for_results();
    run_random(115, 72);
    run_random(115, 0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
sv/spq_pkg.sv
sv/spq_mem.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
bench/sorted_priority_queue_checker.sv
bench/sorted_priority_queue_tb.sv
